>>> hdl/glt_pkg.sv
package glt_pkg;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [2:0] REG_RIGHT_CHANNEL    = 3'd0;
  localparam logic [2:0] REG_AMPLITUDE        = 3'd1;
  localparam logic [2:0] REG_PHASE_STEP       = 3'd2;
  localparam logic [2:0] REG_PHASE_WRAP       = 3'd3;
  localparam logic [2:0] REG_INTERRUPT_LENGTH = 3'd4;

  // Register reset values.
  localparam logic        RST_RIGHT_CHANNEL    = 1'b0;
  localparam logic [14:0] RST_AMPLITUDE        = 15'd6538;
  localparam logic [14:0] RST_PHASE_STEP       = 15'd1365;
  localparam logic [11:0] RST_PHASE_WRAP       = 12'd48;
  localparam logic [15:0] RST_INTERRUPT_LENGTH = 16'd12000;

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_BITS = 2;

  // Pi/2 in Q30.
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // Status of the queue as seen by its producer and consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } glt_qstat_t;

  // One quarter-wave sine entry, sin(pi/2 * r / 2^(addr_bits-2)) scaled to
  // full scale, built by a Q30 Taylor series. Evaluated at elaboration only.
  function automatic logic [31:0] quarter_sine(input int unsigned r,
                                               input int unsigned addr_bits,
                                               input int unsigned sample_bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        peak;
    logic [63:0]        v;
    logic signed [63:0] sum;
    int unsigned        n;
    peak = (64'd1 << (sample_bits - 1)) - 64'd1;
    x    = (64'(r) * PI_HALF_Q30) >> (addr_bits - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > $signed(64'd1 << 30)) begin
      sum = $signed(64'd1 << 30);
    end
    v = ($unsigned(sum) * peak + (64'd1 << 29)) >> 30;
    if (v > peak) begin
      v = peak;
    end
    return v[31:0];
  endfunction

endpackage

>>> hdl/glt_queue.sv
module glt_queue #(
  parameter int unsigned WIDTH = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    head_data,
  output glt_pkg::glt_qstat_t stat
);
  import glt_pkg::*;

  logic [WIDTH-1:0]          mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_r;
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_nxt;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_r;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_nxt;
  logic [QUEUE_PTR_BITS:0]   count_r;
  logic [QUEUE_PTR_BITS:0]   count_nxt;
  logic                      do_push;
  logic                      do_pop;

  // Guard the pointers against a push when full or a pop when empty.
  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  assign stat.full  = (count_r == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_data  = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hdl/glt_front.sv
module glt_front #(
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   tick,
  output logic                   in_ready,
  input  logic                   right_channel,
  input  logic [14:0]            phase_step,
  input  logic [11:0]            phase_wrap,
  input  logic [15:0]            interrupt_length,
  input  glt_pkg::glt_qstat_t    qstat,
  output logic                   push,
  output logic [TABLE_ADDR_BITS:0] push_data
);
  import glt_pkg::*;

  localparam int unsigned AB = TABLE_ADDR_BITS;

  logic [11:0]   phase_count_r;
  logic [11:0]   phase_count_nxt;
  logic [15:0]   phase_accum_r;
  logic [15:0]   phase_accum_nxt;
  logic [19:0]   seq_count_r;
  logic [19:0]   seq_count_nxt;
  logic [20:0]   il_1x;
  logic [20:0]   il_2x;
  logic [20:0]   il_3x;
  logic [20:0]   il_4x;
  logic [20:0]   il_5x;
  logic [20:0]   il_16x;
  logic [20:0]   seq_ext;
  logic          gap;
  logic [AB-1:0] addr;
  logic [AB-3:0] rem;
  logic [AB-2:0] idx;
  logic          negate;

  assign in_ready = !qstat.full;
  assign push     = in_valid && in_ready && tick;

  // Interval boundaries of the muting sequence.
  assign il_1x   = {5'd0, interrupt_length};
  assign il_2x   = {4'd0, interrupt_length, 1'b0};
  assign il_4x   = {3'd0, interrupt_length, 2'b0};
  assign il_3x   = il_1x + il_2x;
  assign il_5x   = il_1x + il_4x;
  assign il_16x  = {1'b0, interrupt_length, 4'd0};
  assign seq_ext = {1'b0, seq_count_r};

  // Classify the sample as muted or audible.
  always_comb begin
    if (right_channel) begin
      gap = (seq_ext >= il_2x && seq_ext < il_3x) ||
            (seq_ext >= il_4x && seq_ext < il_5x);
    end else begin
      gap = seq_ext < il_1x;
    end
  end

  // Fold the full-turn address onto the quarter-wave table.
  assign addr   = phase_accum_r[15 -: AB];
  assign rem    = addr[AB-3:0];
  assign negate = addr[AB-1];
  assign idx    = addr[AB-2] ? ((AB - 1)'(1) << (AB - 2)) - {1'b0, rem} : {1'b0, rem};

  assign push_data = {gap, negate, idx};

  // Advance phase and sequence counters once per produced sample.
  always_comb begin
    phase_count_nxt = phase_count_r;
    phase_accum_nxt = phase_accum_r;
    seq_count_nxt   = seq_count_r;
    if (push) begin
      if ({1'b0, phase_count_r} + 13'd1 >= {1'b0, phase_wrap}) begin
        phase_count_nxt = '0;
        phase_accum_nxt = '0;
      end else begin
        phase_count_nxt = phase_count_r + 12'd1;
        phase_accum_nxt = phase_accum_r + {1'b0, phase_step};
      end
      if (seq_ext + 21'd1 >= il_16x) begin
        seq_count_nxt = '0;
      end else begin
        seq_count_nxt = seq_count_r + 20'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_count_r <= '0;
      phase_accum_r <= '0;
      seq_count_r   <= '0;
    end else begin
      phase_count_r <= phase_count_nxt;
      phase_accum_r <= phase_accum_nxt;
      seq_count_r   <= seq_count_nxt;
    end
  end

endmodule

>>> hdl/glt_back.sv
module glt_back #(
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned SAMPLE_BITS     = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  glt_pkg::glt_qstat_t           qstat,
  input  logic [TABLE_ADDR_BITS:0]      head_data,
  output logic                          pop,
  input  logic [14:0]                   amplitude,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_gap,
  output logic                          lookup_valid
);
  import glt_pkg::*;

  localparam int unsigned AB      = TABLE_ADDR_BITS;
  localparam int unsigned SB      = SAMPLE_BITS;
  localparam int unsigned QUARTER = 1 << (AB - 2);
  localparam int unsigned PW      = SB + 16;

  logic signed [SB-1:0] qtab [QUARTER+1];
  logic [AB-2:0]        idx;
  logic                 negate;
  logic                 gap;
  logic                 look_adv;
  logic                 out_adv;
  logic                 look_v_r;
  logic                 look_v_nxt;
  logic signed [SB-1:0] look_val_r;
  logic signed [SB-1:0] look_val_nxt;
  logic                 look_gap_r;
  logic                 out_v_r;
  logic                 out_v_nxt;
  logic signed [SB-1:0] out_sample_r;
  logic signed [SB-1:0] out_sample_nxt;
  logic                 out_gap_r;
  logic signed [PW-1:0] product;
  logic signed [PW-1:0] rounded;

  // Quarter-wave sine table, constant after elaboration.
  for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
    assign qtab[g] = SB'(quarter_sine(g, AB, SB));
  end

  assign idx    = head_data[AB-2:0];
  assign negate = head_data[AB-1];
  assign gap    = head_data[AB];

  // Stall control: each stage moves when the one after it has room.
  assign out_adv  = !out_v_r || out_ready;
  assign look_adv = !look_v_r || out_adv;
  assign pop      = look_adv && !qstat.empty;

  // Table lookup stage with the sign of the lower half-turn applied.
  assign look_v_nxt   = pop;
  assign look_val_nxt = negate ? -qtab[idx] : qtab[idx];

  // Amplitude scaling with round-half-up back to sample width.
  assign product        = look_val_r * $signed({1'b0, amplitude});
  assign rounded        = product + PW'(1 << 14);
  assign out_v_nxt      = look_v_r;
  assign out_sample_nxt = look_gap_r ? '0 : rounded[SB+14:15];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      look_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (look_adv) begin
        look_v_r <= look_v_nxt;
      end
      if (out_adv) begin
        out_v_r <= out_v_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (look_adv) begin
      look_val_r <= look_val_nxt;
      look_gap_r <= gap;
    end
    if (out_adv) begin
      out_sample_r <= out_sample_nxt;
      out_gap_r    <= look_gap_r;
    end
  end

  assign out_valid    = out_v_r;
  assign out_sample   = out_sample_r;
  assign out_gap      = out_gap_r;
  assign lookup_valid = look_v_r;

endmodule

>>> hdl/glits_lineup_tone_generator.sv
// Line-up tone generator for one channel of a stereo GLITS sequence.
// Input stream: each item carries a tick bit in in_tdata[0]. An item with
// tick high asks for the next sample; an item with tick low is taken and
// dropped without a result and without touching the phase or sequence.
// Output stream: out_tdata holds the signed sample, out_tuser[0] is high
// when the sample lies in a muted interval (the sample is then zero).
// Throughput is one item per cycle while out_tready stays high. A taken
// tick item enters the four-entry queue, then passes the quarter-wave
// table lookup register and the amplitude multiply and rounding register
// before it appears on the output with out_tvalid high.
// When the receiver stalls, the output and lookup stages hold and the
// queue fills; in_tready drops only once the queue is full, so up to six
// samples can be in flight before the input side waits.
// The APB port writes the channel select, amplitude, phase step, phase
// wrap and interval length; registers should change only while idle.
// Reset loads the default 1 kHz at 48 kHz settings, clears the phase and
// sequence counters and empties the queue and the stages.
module glits_lineup_tone_generator #(
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned SAMPLE_BITS     = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [0] tick, [7:1] zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]   out_tdata,  // sample, sign-extended
  output logic [0:0]                         out_tuser,  // [0] in_gap
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [4:0]                         cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import glt_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned DW = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned EW = TABLE_ADDR_BITS + 1;

  logic                 right_channel_r;
  logic [14:0]          amplitude_r;
  logic [14:0]          phase_step_r;
  logic [11:0]          phase_wrap_r;
  logic [15:0]          interrupt_length_r;
  logic                 cfg_write;
  logic [2:0]           cfg_index;
  glt_qstat_t           qstat;
  logic                 push;
  logic                 pop;
  logic [EW-1:0]        push_data;
  logic [EW-1:0]        head_data;
  logic signed [SB-1:0] out_sample;
  logic                 out_gap;
  logic                 lookup_valid;

  // Configuration register writes.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_index  = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_channel_r    <= RST_RIGHT_CHANNEL;
      amplitude_r        <= RST_AMPLITUDE;
      phase_step_r       <= RST_PHASE_STEP;
      phase_wrap_r       <= RST_PHASE_WRAP;
      interrupt_length_r <= RST_INTERRUPT_LENGTH;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RIGHT_CHANNEL:    right_channel_r    <= cfg_pwdata[0];
        REG_AMPLITUDE:        amplitude_r        <= cfg_pwdata[14:0];
        REG_PHASE_STEP:       phase_step_r       <= cfg_pwdata[14:0];
        REG_PHASE_WRAP:       phase_wrap_r       <= cfg_pwdata[11:0];
        REG_INTERRUPT_LENGTH: interrupt_length_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (cfg_index)
      REG_RIGHT_CHANNEL:    cfg_prdata = {31'd0, right_channel_r};
      REG_AMPLITUDE:        cfg_prdata = {17'd0, amplitude_r};
      REG_PHASE_STEP:       cfg_prdata = {17'd0, phase_step_r};
      REG_PHASE_WRAP:       cfg_prdata = {20'd0, phase_wrap_r};
      REG_INTERRUPT_LENGTH: cfg_prdata = {16'd0, interrupt_length_r};
      default:              cfg_prdata = '0;
    endcase
  end

  glt_front #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .tick            (in_tdata[0]),
    .in_ready        (in_tready),
    .right_channel   (right_channel_r),
    .phase_step      (phase_step_r),
    .phase_wrap      (phase_wrap_r),
    .interrupt_length(interrupt_length_r),
    .qstat           (qstat),
    .push            (push),
    .push_data       (push_data)
  );

  glt_queue #(
    .WIDTH(EW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head_data(head_data),
    .stat     (qstat)
  );

  glt_back #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .qstat       (qstat),
    .head_data   (head_data),
    .pop         (pop),
    .amplitude   (amplitude_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_sample  (out_sample),
    .out_gap     (out_gap),
    .lookup_valid(lookup_valid)
  );

  // Sign-extend the sample to whole bytes.
  assign out_tdata = DW'(out_sample);
  assign out_tuser = out_gap;

`ifndef NO_ASSERTIONS
  // A muted sample always carries a zero value.
  a_gap_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_sample == '0)
    else $error("muted sample with nonzero value");

  // The front never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("queue push while full");

  // A stalled output keeps the lookup stage's item in place.
  a_lookup_holds: assert property (@(posedge clk) disable iff (!rst_n)
    lookup_valid && out_tvalid && !out_tready |=> lookup_valid)
    else $error("lookup stage item lost under stall");

  // The back never pops from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("queue pop while empty");
`endif

endmodule
